// File: rtl/command_line_tokenizer_core_assert.svh
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define CLT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication.
`define CLT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// File: rtl/clt_pkg.sv
// Shared types and constants of the command line tokenizer.
package clt_pkg;

	localparam int LINE_MAX   = 256;
	localparam int MAX_PARAMS = 10;
	localparam int CAP_W      = 9;
	localparam int OFF_W      = 8;
	localparam int PCNT_W     = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	typedef enum logic [3:0] {
		PH_INIT, PH_POSTCMD, PH_SEP, PH_MINUS, PH_NUMBER,
		PH_STRING, PH_SKIP, PH_EOL, PH_END
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE, ERR_MALFORMED, ERR_OVERLONG, ERR_TOOMANY
	} err_t;

	typedef enum logic [1:0] {
		EV_NONE, EV_PARAM, EV_LINE
	} event_t;

	typedef struct packed {
		logic              write_valid;
		logic [OFF_W-1:0]  write_offset;
		logic [7:0]        write_byte;
		event_t            event_res;
		logic [3:0]        param_index;
		logic              param_is_number;
		logic [31:0]       param_value;
		logic [OFF_W-1:0]  param_start;
		logic [CAP_W-1:0]  param_length;
		logic [7:0]        command_letter;
		logic [3:0]        param_count;
		err_t              error_code;
	} result_t;

endpackage

// File: rtl/command_line_tokenizer_core.sv
// Command line tokenizer: CR-LF line parser with line store reporting.
// One text byte enters per request on the s_ channel and one result leaves per byte on the
// m_ channel. A byte passes an input register, then the parsing logic (phase step and a
// multiply-by-ten saturating accumulate) into a result register, and a new byte is taken
// every cycle while results are being taken. The line
// capacity register is written over the cfg_ channel (always ready, reset 256; 0 acts as 1).
`include "command_line_tokenizer_core_assert.svh"

module command_line_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// write_valid[0], write_offset[8:1], write_byte[16:9], param_index[20:17],
	// param_is_number[21], param_value[53:22], param_start[61:54], param_length[70:62],
	// command_letter[78:71], param_count[82:79], error_code[84:83], zero pad [87:85]
	output logic [87:0] m_tdata,
	output logic [1:0]  m_tuser,   // event_res[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data   // line_capacity[8:0]
);
	import clt_pkg::*;

	logic [CAP_W-1:0] cap_reg_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             out_valid_q;
	result_t          res_q;
	result_t          res;

	phase_t            phase_q, phase_n, ph0, ph1;
	logic [CAP_W-1:0]  fill_q, fill_n, fill0;
	logic [PCNT_W-1:0] params_q, params_n, params0;
	logic [7:0]        cmd_q, cmd_n, cmd0;
	err_t              err_q, err_n, err0, err1;
	logic [OFF_W-1:0]  tstart_q, tstart_n;
	logic [CAP_W-1:0]  tlen_q, tlen_n;
	logic [31:0]       tmag_q, tmag_n;
	logic              tneg_q, tneg_n;

	logic [CAP_W-1:0] cap;
	logic             line_start, try_store, full, store;
	logic             is_blank, is_digit, is_letter, is_cr, is_lf, is_minus;
	logic             in_token, pdone, ldone;
	logic [3:0]       digit;
	logic [35:0]      acc_sum;
	logic [31:0]      acc_lim, acc_val;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	// Clamp capacity into 1..LINE_MAX
	always_comb begin
		cap = cap_reg_q;
		if (cap_reg_q == '0)
			cap = CAP_W'(1);
		else if (cap_reg_q > CAP_W'(LINE_MAX))
			cap = CAP_W'(LINE_MAX);
	end

	assign line_start = (phase_q == PH_END);
	assign ph0        = line_start ? PH_INIT : phase_q;
	assign fill0      = line_start ? '0 : fill_q;
	assign params0    = line_start ? '0 : params_q;
	assign cmd0       = line_start ? '0 : cmd_q;
	assign err0       = line_start ? ERR_NONE : err_q;

	assign try_store = (ph0 != PH_SKIP) && (ph0 != PH_EOL);
	assign full      = try_store && (fill0 >= cap);
	assign store     = try_store && !full;
	assign ph1       = full ? PH_SKIP : ph0;
	assign err1      = full ? ERR_OVERLONG : err0;

	assign is_blank  = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);
	assign is_digit  = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign is_letter = ((byte_s1 >= CH_UA) && (byte_s1 <= CH_UZ)) ||
	                   ((byte_s1 >= CH_LA) && (byte_s1 <= CH_LZ));
	assign is_cr     = (byte_s1 == CH_CR);
	assign is_lf     = (byte_s1 == CH_LF);
	assign is_minus  = (byte_s1 == CH_MINUS);
	assign digit     = 4'(byte_s1 - CH_0);

	assign in_token = (ph1 == PH_MINUS) || (ph1 == PH_NUMBER) || (ph1 == PH_STRING);
	assign pdone    = in_token && (is_blank || is_cr);
	assign ldone    = (ph1 == PH_EOL) && is_lf;

	// Saturating magnitude * 10 + digit
	assign acc_sum = {1'b0, tmag_q, 3'b000} + {3'b000, tmag_q, 1'b0} + {32'd0, digit};
	assign acc_lim = tneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign acc_val = (acc_sum > {4'd0, acc_lim}) ? acc_lim : acc_sum[31:0];

	// Next state
	always_comb begin
		phase_n  = ph1;
		fill_n   = store ? fill0 + CAP_W'(1) : fill0;
		params_n = params0;
		cmd_n    = cmd0;
		err_n    = err1;
		tstart_n = tstart_q;
		tlen_n   = tlen_q;
		tmag_n   = tmag_q;
		tneg_n   = tneg_q;
		unique case (ph1)
			PH_INIT: begin
				if (is_blank) begin
					phase_n = PH_INIT;
				end else if (is_letter) begin
					phase_n = PH_POSTCMD;
					cmd_n   = byte_s1;
				end else if (is_cr) begin
					phase_n = PH_EOL;
				end else begin
					phase_n = PH_SKIP;
					err_n   = ERR_MALFORMED;
				end
			end
			PH_POSTCMD: begin
				if (is_blank) begin
					phase_n = PH_SEP;
				end else if (is_cr) begin
					phase_n = PH_EOL;
				end else begin
					phase_n = PH_SKIP;
					err_n   = ERR_MALFORMED;
				end
			end
			PH_SEP: begin
				if (is_blank) begin
					phase_n = PH_SEP;
				end else if (is_cr) begin
					phase_n = PH_EOL;
				end else if (params0 >= PCNT_W'(MAX_PARAMS)) begin
					phase_n = PH_SKIP;
					err_n   = ERR_TOOMANY;
				end else begin
					params_n = params0 + PCNT_W'(1);
					tstart_n = fill0[OFF_W-1:0];
					tlen_n   = CAP_W'(1);
					tneg_n   = is_minus;
					tmag_n   = is_digit ? {28'd0, digit} : 32'd0;
					if (is_minus)
						phase_n = PH_MINUS;
					else if (is_digit)
						phase_n = PH_NUMBER;
					else
						phase_n = PH_STRING;
				end
			end
			PH_MINUS, PH_NUMBER, PH_STRING: begin
				if (is_blank || is_cr) begin
					phase_n = is_cr ? PH_EOL : PH_SEP;
				end else begin
					if (tlen_q != '1)
						tlen_n = tlen_q + CAP_W'(1);
					if (ph1 != PH_STRING && is_digit) begin
						phase_n = PH_NUMBER;
						tmag_n  = acc_val;
					end else begin
						phase_n = PH_STRING;
					end
				end
			end
			PH_SKIP: begin
				if (is_cr)
					phase_n = PH_EOL;
			end
			PH_EOL: begin
				if (is_lf) begin
					phase_n = PH_END;
				end else begin
					phase_n = PH_SKIP;
					err_n   = ERR_MALFORMED;
				end
			end
			default: phase_n = PH_INIT;
		endcase
	end

	// Result fields
	always_comb begin
		res = '0;
		if (store) begin
			res.write_valid  = 1'b1;
			res.write_offset = fill0[OFF_W-1:0];
			res.write_byte   = pdone ? 8'd0 : byte_s1;
		end
		if (pdone) begin
			res.event_res       = EV_PARAM;
			res.param_index     = params0 - PCNT_W'(1);
			res.param_is_number = (ph1 == PH_NUMBER);
			if (ph1 == PH_NUMBER)
				res.param_value = tneg_q ? (32'd0 - tmag_q) : tmag_q;
			res.param_start     = tstart_q;
			res.param_length    = tlen_q;
		end else if (ldone) begin
			res.event_res      = EV_LINE;
			res.command_letter = cmd0;
			res.param_count    = params0;
			res.error_code     = err1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q <= CAP_W'(LINE_MAX);
		end else if (cfg_valid && cfg_ready) begin
			cap_reg_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INIT;
			fill_q   <= '0;
			params_q <= '0;
			cmd_q    <= '0;
			err_q    <= ERR_NONE;
			tstart_q <= '0;
			tlen_q   <= '0;
			tmag_q   <= '0;
			tneg_q   <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_n;
			fill_q   <= fill_n;
			params_q <= params_n;
			cmd_q    <= cmd_n;
			err_q    <= err_n;
			tstart_q <= tstart_n;
			tlen_q   <= tlen_n;
			tmag_q   <= tmag_n;
			tneg_q   <= tneg_n;
		end
	end

	// Result register: hold while the result is not taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.event_res;
	assign m_tdata  = {3'b000, res_q.error_code, res_q.param_count, res_q.command_letter,
	                   res_q.param_length, res_q.param_start, res_q.param_value,
	                   res_q.param_is_number, res_q.param_index, res_q.write_byte,
	                   res_q.write_offset, res_q.write_valid};

	`CLT_ASSERT_IMP(a_param_term_stored, m_tvalid && m_tuser == EV_PARAM, m_tdata[0] && m_tdata[16:9] == 8'd0)
	`CLT_ASSERT_IMP(a_line_not_stored, m_tvalid && m_tuser == EV_LINE, !m_tdata[0])
	`CLT_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CAP_W'(LINE_MAX))
	`CLT_ASSERT_NXT(a_stall_holds_s1, valid_s1 && !advance, valid_s1 && $stable(byte_s1))

endmodule
